@@ design/framed_command_receiver_macros.svh @@
// assertion macros for the framed command receiver checker
`ifndef FRAMED_COMMAND_RECEIVER_MACROS_SVH
`define FRAMED_COMMAND_RECEIVER_MACROS_SVH

// same-cycle implication
`define FCR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/fcr_pkg.sv @@
// shared types, codes and constants of the framed command receiver
package fcr_pkg;

    localparam int DEF_MAX_PAYLOAD = 32;

    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_OVERRUN = 2'd2;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_STATUS  = 2'd1;
    localparam logic [1:0] KIND_REPLY   = 2'd2;

    localparam logic CFG_FRAME_TO = 1'b0;
    localparam logic CFG_GAP_TO   = 1'b1;

    localparam logic [7:0] START_BYTE = 8'h53;
    localparam logic [7:0] END_BYTE   = 8'h45;
    localparam logic [7:0] REPLY_HEAD = 8'hFE;
    localparam logic [7:0] REPLY_CSUM = 8'h43;
    localparam logic [7:0] REPLY_TAIL = 8'h00;

    localparam logic [7:0] FRAME_TO_RESET = 8'd200;
    localparam logic [7:0] GAP_TO_RESET   = 8'd20;

    typedef struct packed {
        logic       start;
        logic       reply;
        logic [7:0] len;
    } fcr_burst_t;

    function automatic logic [7:0] sat_inc(input logic [7:0] a);
        return (a == 8'hFF) ? 8'hFF : a + 8'd1;
    endfunction

endpackage

@@ design/framed_command_receiver.sv @@
// framed command receiver top level: parser, payload store and result sequencer
// an input transfer is taken every cycle while no result burst is being sent
// a good frame's end byte sets the busy register, then the output registers take its first
// result, then one per cycle while out_ready is high (length + 1 results); a checksum reply
// is three results; input is held off while busy, limited by the single store read port
// reset clears parser and sequencer state and loads timeouts 200 and 20; store is not cleared
module framed_command_receiver #(
    parameter int MAX_PAYLOAD = fcr_pkg::DEF_MAX_PAYLOAD
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] op,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] value,
    output logic       final_res
);
    import fcr_pkg::*;

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic          accept;
    logic          busy;
    logic          st_we;
    logic [AW-1:0] st_waddr;
    logic [7:0]    st_wdata;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    fcr_burst_t    burst;

    assign in_ready = !busy;
    assign accept   = in_valid && in_ready;

    fcr_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .accept   (accept),
        .op       (op),
        .rx_byte  (rx_byte),
        .st_we    (st_we),
        .st_waddr (st_waddr),
        .st_wdata (st_wdata),
        .burst    (burst)
    );

    fcr_ram #(
        .WIDTH(8),
        .DEPTH(MAX_PAYLOAD)
    ) u_store (
        .clk  (clk),
        .we   (st_we),
        .waddr(st_waddr),
        .wdata(st_wdata),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    fcr_emitter #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .burst    (burst),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .busy     (busy),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind     (kind),
        .value    (value),
        .final_res(final_res)
    );

endmodule

@@ design/fcr_ram.sv @@
// generic single-port-write ram with registered read
module fcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/fcr_parser.sv @@
// frame parser: position tracking, checksum, timeouts and timeout registers
module fcr_parser #(
    parameter int MAX_PAYLOAD = fcr_pkg::DEF_MAX_PAYLOAD,
    parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               accept,
    input  logic [1:0]         op,
    input  logic [7:0]         rx_byte,
    output logic               st_we,
    output logic [AW-1:0]      st_waddr,
    output logic [7:0]         st_wdata,
    output fcr_pkg::fcr_burst_t burst
);
    import fcr_pkg::*;

    localparam int POS_W = $clog2(MAX_PAYLOAD + 4);
    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0] exp_len_reg, exp_len_next;
    logic [7:0]       run_sum_reg, run_sum_next;
    logic [7:0]       snd_sum_reg, snd_sum_next;
    logic [7:0]       frame_age_reg, frame_age_next;
    logic [7:0]       gap_age_reg, gap_age_next;
    logic [7:0]       frame_to_reg, frame_to_next;
    logic [7:0]       gap_to_reg, gap_to_next;
    logic [POS_W-1:0] pay_idx;
    logic [POS_W-1:0] exp_len_ext;
    logic [7:0]       frame_age_inc;
    logic [7:0]       gap_age_inc;

    assign pay_idx       = pos_reg - POS_W'(2);
    assign exp_len_ext   = POS_W'(exp_len_reg);
    assign frame_age_inc = sat_inc(frame_age_reg);
    assign gap_age_inc   = sat_inc(gap_age_reg);
    assign st_waddr      = pay_idx[AW-1:0];
    assign st_wdata      = rx_byte;

    always_comb
    begin
        frame_to_next = frame_to_reg;
        gap_to_next   = gap_to_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_TO: frame_to_next = cfg_data;
                CFG_GAP_TO:   gap_to_next   = cfg_data;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        pos_next       = pos_reg;
        exp_len_next   = exp_len_reg;
        run_sum_next   = run_sum_reg;
        snd_sum_next   = snd_sum_reg;
        frame_age_next = frame_age_reg;
        gap_age_next   = gap_age_reg;
        st_we          = 1'b0;
        burst          = '0;
        if (accept)
        begin
            case (op)
                OP_OVERRUN:
                begin
                    pos_next       = '0;
                    frame_age_next = '0;
                    gap_age_next   = '0;
                end
                OP_TICK:
                begin
                    if (pos_reg != '0)
                    begin
                        frame_age_next = frame_age_inc;
                        gap_age_next   = gap_age_inc;
                        if ((frame_age_inc > frame_to_reg) || (gap_age_inc > gap_to_reg))
                        begin
                            pos_next       = '0;
                            frame_age_next = '0;
                            gap_age_next   = '0;
                        end
                    end
                end
                OP_BYTE:
                begin
                    gap_age_next = '0;
                    if (pos_reg == '0)
                    begin
                        if (rx_byte == START_BYTE)
                        begin
                            pos_next       = POS_W'(1);
                            frame_age_next = '0;
                        end
                    end
                    else if (pos_reg == POS_W'(1))
                    begin
                        if (rx_byte > MAX_LEN)
                        begin
                            pos_next       = '0;
                            frame_age_next = '0;
                        end
                        else
                        begin
                            exp_len_next = rx_byte[LEN_W-1:0];
                            run_sum_next = '0;
                            pos_next     = POS_W'(2);
                        end
                    end
                    else if (pay_idx < exp_len_ext)
                    begin
                        st_we        = 1'b1;
                        run_sum_next = run_sum_reg + rx_byte;
                        pos_next     = pos_reg + POS_W'(1);
                    end
                    else if (pay_idx == exp_len_ext)
                    begin
                        snd_sum_next = rx_byte;
                        pos_next     = pos_reg + POS_W'(1);
                    end
                    else
                    begin
                        // end byte phase: checksum decides the reply
                        if (rx_byte == END_BYTE)
                        begin
                            burst.start = 1'b1;
                            burst.reply = (run_sum_reg != snd_sum_reg);
                            burst.len   = 8'(exp_len_reg);
                        end
                        pos_next       = '0;
                        frame_age_next = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            exp_len_reg   <= '0;
            run_sum_reg   <= '0;
            snd_sum_reg   <= '0;
            frame_age_reg <= '0;
            gap_age_reg   <= '0;
            frame_to_reg  <= FRAME_TO_RESET;
            gap_to_reg    <= GAP_TO_RESET;
        end
        else
        begin
            pos_reg       <= pos_next;
            exp_len_reg   <= exp_len_next;
            run_sum_reg   <= run_sum_next;
            snd_sum_reg   <= snd_sum_next;
            frame_age_reg <= frame_age_next;
            gap_age_reg   <= gap_age_next;
            frame_to_reg  <= frame_to_next;
            gap_to_reg    <= gap_to_next;
        end
    end

endmodule

@@ design/fcr_emitter.sv @@
// result sequencer: plays back the payload store or the checksum reply
module fcr_emitter #(
    parameter int MAX_PAYLOAD = fcr_pkg::DEF_MAX_PAYLOAD,
    parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fcr_pkg::fcr_burst_t burst,
    output logic [AW-1:0]      rd_addr,
    input  logic [7:0]         rd_data,
    output logic               busy,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         kind,
    output logic [7:0]         value,
    output logic               final_res
);
    import fcr_pkg::*;

    localparam int CNT_W = ($clog2(MAX_PAYLOAD + 1) > 2) ? $clog2(MAX_PAYLOAD + 1) : 2;

    logic             busy_reg, busy_next;
    logic             reply_reg, reply_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       kind_reg, kind_next;
    logic [7:0]       value_reg, value_next;
    logic             final_reg, final_next;
    logic             load;

    assign load = busy_reg && (!out_valid_reg || out_ready);

    always_comb
    begin
        busy_next      = busy_reg;
        reply_next     = reply_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        value_next     = value_reg;
        final_next     = final_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = idx_reg + CNT_W'(1);
            if (reply_reg)
            begin
                kind_next = KIND_REPLY;
                case (idx_reg)
                    CNT_W'(0):
                    begin
                        value_next = REPLY_HEAD;
                        final_next = 1'b0;
                    end
                    CNT_W'(1):
                    begin
                        value_next = REPLY_CSUM;
                        final_next = 1'b0;
                    end
                    default:
                    begin
                        value_next = REPLY_TAIL;
                        final_next = 1'b1;
                        busy_next  = 1'b0;
                    end
                endcase
            end
            else if (idx_reg < len_reg)
            begin
                kind_next  = KIND_PAYLOAD;
                value_next = rd_data;
                final_next = 1'b0;
            end
            else
            begin
                kind_next  = KIND_STATUS;
                value_next = 8'(len_reg);
                final_next = 1'b1;
                busy_next  = 1'b0;
            end
        end
        if (burst.start)
        begin
            busy_next  = 1'b1;
            reply_next = burst.reply;
            len_next   = CNT_W'(burst.len);
            idx_next   = '0;
        end
    end

    // read address follows the next index so the data lines up with idx_reg
    assign rd_addr = idx_next[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            reply_reg     <= 1'b0;
            len_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            reply_reg     <= reply_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        value_reg <= value_next;
        final_reg <= final_next;
    end

    assign busy      = busy_reg;
    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign value     = value_reg;
    assign final_res = final_reg;

endmodule

@@ design/fcr_checker.sv @@
// port-level checker for the framed command receiver and its bind
`include "framed_command_receiver_macros.svh"

module fcr_checker #(
    parameter int MAX_PAYLOAD = fcr_pkg::DEF_MAX_PAYLOAD
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] op,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] kind,
    input logic [7:0] value,
    input logic       final_res
);
    import fcr_pkg::*;

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    `FCR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(kind) && $stable(value) && $stable(final_res),
        "result changed while stalled")

    `FCR_ASSERT_NEXT(a_no_stall_after_nonbyte, in_valid && in_ready && (op != OP_BYTE),
        in_ready, "non-byte transfer started a burst")

    `FCR_ASSERT_NOW(a_final_marks_status, out_valid && (kind != KIND_REPLY),
        final_res == (kind == KIND_STATUS), "final flag does not match status result")

    `FCR_ASSERT_NOW(a_status_len, out_valid && (kind == KIND_STATUS),
        value <= MAX_LEN, "status length above store size")

    `FCR_ASSERT_NEXT(a_reply_order,
        out_valid && out_ready && (kind == KIND_REPLY) && (value == REPLY_HEAD),
        out_valid && (kind == KIND_REPLY) && (value == REPLY_CSUM),
        "reply head not followed by checksum code")

endmodule

bind framed_command_receiver fcr_checker #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
) u_fcr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind     (kind),
    .value    (value),
    .final_res(final_res)
);
